// ----- rtl/core/gbn_pkg.sv -----
// Shared types and constants for the go-back-n sender window.
`timescale 1ns / 1ps
package gbn_pkg;

    localparam int OP_W   = 2;
    localparam int TAG_W  = 16;
    localparam int LEN_W  = 11;
    localparam int SEQ_W  = 32;
    localparam int WIN_W  = 5;
    localparam logic [WIN_W-1:0] WIN_RESET = 5'd8;

    typedef enum logic [OP_W-1:0] {
        OP_NEW     = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_END     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_SEND    = 2'd0,
        KIND_RESEND  = 2'd1,
        KIND_FIN     = 2'd2,
        KIND_REFUSED = 2'd3
    } t_kind;

    typedef struct packed {
        logic new_pkt;
        logic ack;
        logic end_data;
        logic rs_start;
        logic rs_read;
        logic rs_emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic rs_last;
    } t_status;

endpackage

// ----- rtl/core/go_back_n_sender_window.sv -----
// Top level of the go-back-n sender window.
//
//   channel   direction  handshake                   payload
//   request   in         i_valid / o_ready           operation, tag, length, ack, ack_good
//   result    out        o_valid / i_ready           kind, seq_number, tag, length, last
//   window    in         i_cfg_valid / o_cfg_ready   window_size (5 bits)
//
// New-packet, ack and end-of-data requests are handled in the idle state.
// A timeout with packets outstanding starts a resend sweep that alternates a registered
// read of the packet store (S_READ) with an emit (S_EMIT) for each outstanding packet.
// Reset empties the window and restores window_size to 8; no clearing pass.
// A stalled result register holds further requests and the resend sweep.
`timescale 1ns / 1ps
module go_back_n_sender_window #(
    parameter int WINDOW_MAX  = 16,
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [gbn_pkg::OP_W-1:0]    i_operation,
    input  logic [gbn_pkg::TAG_W-1:0]   i_payload_tag,
    input  logic [gbn_pkg::LEN_W-1:0]   i_payload_length,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_ack_number,
    input  logic                        i_ack_good,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_kind,
    output logic [gbn_pkg::SEQ_W-1:0]   o_seq_number,
    output logic [gbn_pkg::TAG_W-1:0]   o_out_tag,
    output logic [gbn_pkg::LEN_W-1:0]   o_out_length,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gbn_pkg::WIN_W-1:0]   i_cfg_data
);
    import gbn_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    gbn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_status    (status),
        .o_ready     (o_ready),
        .o_cmd       (cmd)
    );

    gbn_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_payload_tag    (i_payload_tag),
        .i_payload_length (i_payload_length),
        .i_ack_number     (i_ack_number),
        .i_ack_good       (i_ack_good),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_kind           (o_kind),
        .o_seq_number     (o_seq_number),
        .o_out_tag        (o_out_tag),
        .o_out_length     (o_out_length),
        .o_last           (o_last)
    );

endmodule

// ----- rtl/core/gbn_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/gbn_ctrl.sv -----
// Sequencer for request decode and the resend sweep.
`timescale 1ns / 1ps
module gbn_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [gbn_pkg::OP_W-1:0]  i_operation,
    input  gbn_pkg::t_status          i_status,
    output logic                      o_ready,
    output gbn_pkg::t_cmd             o_cmd
);
    import gbn_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_ready;
    t_cmd   cmd;

    always_comb begin
        n_state  = r_state;
        cmd      = '0;
        in_ready = (r_state == S_IDLE) && i_status.out_free;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && in_ready) begin
                    unique case (t_op'(i_operation))
                        OP_NEW: cmd.new_pkt = 1'b1;
                        OP_ACK: cmd.ack = 1'b1;
                        OP_TIMEOUT: begin
                            if (!i_status.count_zero) begin
                                cmd.rs_start = 1'b1;
                                n_state      = S_READ;
                            end
                        end
                        OP_END: cmd.end_data = 1'b1;
                        default: cmd = '0;
                    endcase
                end
            end
            S_READ: begin
                cmd.rs_read = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    cmd.rs_emit = 1'b1;
                    n_state     = i_status.rs_last ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = in_ready;
    assign o_cmd   = cmd;

endmodule

// ----- rtl/core/gbn_dp.sv -----
// Window state, packet store and result register.
`timescale 1ns / 1ps
module gbn_dp #(
    parameter int WINDOW_MAX  = 16,
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gbn_pkg::t_cmd               i_cmd,
    output gbn_pkg::t_status            o_status,
    input  logic                        i_cfg_we,
    input  logic [gbn_pkg::WIN_W-1:0]   i_cfg_data,
    input  logic [gbn_pkg::TAG_W-1:0]   i_payload_tag,
    input  logic [gbn_pkg::LEN_W-1:0]   i_payload_length,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_ack_number,
    input  logic                        i_ack_good,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [1:0]                  o_kind,
    output logic [gbn_pkg::SEQ_W-1:0]   o_seq_number,
    output logic [gbn_pkg::TAG_W-1:0]   o_out_tag,
    output logic [gbn_pkg::LEN_W-1:0]   o_out_length,
    output logic                        o_last
);
    import gbn_pkg::*;

    localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int DW = TAG_W + LEN_W;
    localparam logic [SW:0]    WRAP     = (SW+1)'(WINDOW_MAX);
    localparam logic [31:0]    WIN_MAX32 = 32'(WINDOW_MAX);
    localparam logic [31:0]    LEN_CAP  = 32'(MAX_PAYLOAD);

    logic [SEQ_W-1:0] r_base, n_base;
    logic [SEQ_W-1:0] r_next_seq, n_next_seq;
    logic [CW-1:0]    r_count, n_count;
    logic [SW-1:0]    r_base_slot, n_base_slot;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_data_ended, n_data_ended;
    logic             r_fin_done, n_fin_done;
    logic [WIN_W-1:0] r_window;

    logic             r_o_valid, n_o_valid;
    logic [1:0]       r_kind, n_kind;
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_last, n_last;

    logic             out_free;
    logic [31:0]      eff_win;
    logic [LEN_W-1:0] len_sat;
    logic             refuse;
    logic [SEQ_W-1:0] ack_offset;
    logic             ack_ok;
    logic [CW-1:0]    ack_step;
    logic [SW:0]      wr_sum, ack_sum, rd_sum;
    logic [SW-1:0]    wr_slot, ack_slot, rd_slot;
    logic             rs_last;
    logic             wr_en;
    logic [DW-1:0]    rd_data;

    assign out_free = !r_o_valid || i_out_ready;

    always_comb begin
        if (r_window == '0) begin
            eff_win = 32'd1;
        end else if (32'(r_window) > WIN_MAX32) begin
            eff_win = WIN_MAX32;
        end else begin
            eff_win = 32'(r_window);
        end
    end

    assign len_sat = (32'(i_payload_length) > LEN_CAP) ? LEN_CAP[LEN_W-1:0]
                                                        : i_payload_length;
    assign refuse  = r_data_ended || r_fin_done || (i_payload_length == '0) ||
                     (32'(r_count) >= eff_win);

    assign ack_offset = i_ack_number - r_base;
    assign ack_ok     = i_ack_good && (ack_offset < 32'(r_count));
    assign ack_step   = CW'(ack_offset) + CW'(1);

    assign wr_sum   = {1'b0, r_base_slot} + (SW+1)'(r_count);
    assign wr_slot  = (wr_sum >= WRAP) ? SW'(wr_sum - WRAP) : SW'(wr_sum);
    assign ack_sum  = {1'b0, r_base_slot} + (SW+1)'(ack_step);
    assign ack_slot = (ack_sum >= WRAP) ? SW'(ack_sum - WRAP) : SW'(ack_sum);
    assign rd_sum   = {1'b0, r_base_slot} + (SW+1)'(r_idx);
    assign rd_slot  = (rd_sum >= WRAP) ? SW'(rd_sum - WRAP) : SW'(rd_sum);

    assign rs_last = ((r_idx + CW'(1)) == r_count);
    assign wr_en   = i_cmd.new_pkt && !refuse;

    gbn_ram #(
        .WIDTH (DW),
        .DEPTH (WINDOW_MAX),
        .AW    (SW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_slot),
        .i_wr_data ({i_payload_tag, len_sat}),
        .i_rd_en   (i_cmd.rs_read),
        .i_rd_addr (rd_slot),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_base       = r_base;
        n_next_seq   = r_next_seq;
        n_count      = r_count;
        n_base_slot  = r_base_slot;
        n_idx        = r_idx;
        n_data_ended = r_data_ended;
        n_fin_done   = r_fin_done;
        n_o_valid    = r_o_valid && !i_out_ready;
        n_kind       = r_kind;
        n_seq        = r_seq;
        n_tag        = r_tag;
        n_len        = r_len;
        n_last       = r_last;

        if (i_cmd.new_pkt) begin
            n_o_valid = 1'b1;
            n_seq     = r_next_seq;
            n_last    = 1'b1;
            if (refuse) begin
                n_kind = KIND_REFUSED;
                n_tag  = '0;
                n_len  = '0;
            end else begin
                n_kind     = KIND_SEND;
                n_tag      = i_payload_tag;
                n_len      = len_sat;
                n_next_seq = r_next_seq + SEQ_W'(1);
                n_count    = r_count + CW'(1);
            end
        end

        if (i_cmd.ack && ack_ok) begin
            n_base      = i_ack_number + SEQ_W'(1);
            n_base_slot = ack_slot;
            n_count     = r_count - ack_step;
        end

        if (i_cmd.end_data) begin
            n_data_ended = 1'b1;
            if (!r_fin_done && r_count == '0) begin
                n_fin_done = 1'b1;
                n_o_valid  = 1'b1;
                n_kind     = KIND_FIN;
                n_seq      = r_next_seq;
                n_tag      = '0;
                n_len      = '0;
                n_last     = 1'b1;
            end
        end

        if (i_cmd.rs_start) begin
            n_idx = '0;
        end

        if (i_cmd.rs_emit) begin
            n_o_valid = 1'b1;
            n_kind    = KIND_RESEND;
            n_seq     = r_base + SEQ_W'(r_idx);
            n_tag     = rd_data[DW-1:LEN_W];
            n_len     = rd_data[LEN_W-1:0];
            n_last    = rs_last;
            n_idx     = r_idx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_next_seq   <= '0;
            r_count      <= '0;
            r_base_slot  <= '0;
            r_idx        <= '0;
            r_data_ended <= 1'b0;
            r_fin_done   <= 1'b0;
            r_window     <= WIN_RESET;
            r_o_valid    <= 1'b0;
        end else begin
            r_base       <= n_base;
            r_next_seq   <= n_next_seq;
            r_count      <= n_count;
            r_base_slot  <= n_base_slot;
            r_idx        <= n_idx;
            r_data_ended <= n_data_ended;
            r_fin_done   <= n_fin_done;
            r_o_valid    <= n_o_valid;
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_seq  <= n_seq;
        r_tag  <= n_tag;
        r_len  <= n_len;
        r_last <= n_last;
    end

    assign o_status.out_free   = out_free;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.rs_last    = rs_last;

    assign o_out_valid  = r_o_valid;
    assign o_kind       = r_kind;
    assign o_seq_number = r_seq;
    assign o_out_tag    = r_tag;
    assign o_out_length = r_len;
    assign o_last       = r_last;

endmodule

// ----- sim/tb_go_back_n_sender_window.sv -----
// Testbench for the go-back-n sender window, checked against an in-bench window model.
`timescale 1ns / 1ps
module tb_go_back_n_sender_window;
    import gbn_pkg::*;

    localparam int SLOTS         = 16;
    localparam int MAX_LEN       = 1024;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
    localparam int STALL_LIMIT   = 4000;

    typedef struct packed {
        t_kind            kind;
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_tx;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_valid          = 1'b0;
    logic [OP_W-1:0]    i_operation      = OP_NEW;
    logic [TAG_W-1:0]   i_payload_tag    = '0;
    logic [LEN_W-1:0]   i_payload_length = '0;
    logic [SEQ_W-1:0]   i_ack_number     = '0;
    logic               i_ack_good       = 1'b0;
    logic               i_ready          = 1'b0;
    logic               i_cfg_valid      = 1'b0;
    logic [WIN_W-1:0]   i_cfg_data       = '0;
    logic               o_ready;
    logic               o_valid;
    logic [1:0]         o_kind;
    logic [SEQ_W-1:0]   o_seq_number;
    logic [TAG_W-1:0]   o_out_tag;
    logic [LEN_W-1:0]   o_out_length;
    logic               o_last;
    logic               o_cfg_ready;

    go_back_n_sender_window #(
        .WINDOW_MAX  (SLOTS),
        .MAX_PAYLOAD (MAX_LEN)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_payload_tag    (i_payload_tag),
        .i_payload_length (i_payload_length),
        .i_ack_number     (i_ack_number),
        .i_ack_good       (i_ack_good),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_seq_number     (o_seq_number),
        .o_out_tag        (o_out_tag),
        .o_out_length     (o_out_length),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [WIN_W-1:0] win_cfg      = WIN_RESET;
    logic [SEQ_W-1:0] base_seq     = '0;
    logic [SEQ_W-1:0] next_seq     = '0;
    logic [TAG_W-1:0] ring_tag [SLOTS];
    logic [LEN_W-1:0] ring_len [SLOTS];
    int               head_slot    = 0;
    logic             stream_ended = 1'b0;
    logic             fin_sent     = 1'b0;
    t_tx              tx_queue [$];

    int req_gap_pct   = 38;
    int rsp_stall_pct = 38;
    int error_count   = 0;
    int idle_cycles   = 0;

    function automatic void queue_tx(input t_kind kind, input logic [SEQ_W-1:0] seq,
            input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len, input logic last);
        t_tx tx;
        tx.kind = kind;
        tx.seq  = seq;
        tx.tag  = tag;
        tx.len  = len;
        tx.last = last;
        tx_queue = {tx_queue, tx};
    endfunction

    function automatic void predict_request(input t_op op, input logic [TAG_W-1:0] tag,
            input logic [LEN_W-1:0] len, input logic [SEQ_W-1:0] ack, input logic ack_ok);
        logic [SEQ_W-1:0] busy;
        logic [SEQ_W-1:0] offset;
        logic [SEQ_W-1:0] limit;
        logic [LEN_W-1:0] clen;
        int               slot;
        busy  = next_seq - base_seq;
        limit = (win_cfg == 0) ? 1 : ((win_cfg > SLOTS) ? SLOTS : win_cfg);
        case (op)
            OP_NEW: begin
                clen = (len > MAX_LEN) ? LEN_W'(MAX_LEN) : len;
                if (stream_ended || fin_sent || clen == 0 || busy >= limit) begin
                    queue_tx(KIND_REFUSED, next_seq, '0, '0, 1'b1);
                end else begin
                    slot = (head_slot + int'(busy)) % SLOTS;
                    ring_tag[slot] = tag;
                    ring_len[slot] = clen;
                    queue_tx(KIND_SEND, next_seq, tag, clen, 1'b1);
                    next_seq = next_seq + 1;
                end
            end
            OP_ACK: begin
                offset = ack - base_seq;
                if (ack_ok && offset < busy) begin
                    base_seq  = ack + 1;
                    head_slot = (head_slot + int'(offset) + 1) % SLOTS;
                end
            end
            OP_TIMEOUT: begin
                for (int i = 0; i < busy && i < SLOTS; i++) begin
                    slot = (head_slot + i) % SLOTS;
                    queue_tx(KIND_RESEND, base_seq + i, ring_tag[slot], ring_len[slot],
                             (i + 1 == busy));
                end
            end
            default: begin
                stream_ended = 1'b1;
                if (!fin_sent && busy == 0) begin
                    fin_sent = 1'b1;
                    queue_tx(KIND_FIN, next_seq, '0, '0, 1'b1);
                end
            end
        endcase
    endfunction

    task automatic send_request(input t_op op, input logic [TAG_W-1:0] tag,
            input logic [LEN_W-1:0] len, input logic [SEQ_W-1:0] ack, input logic good);
        while ($urandom_range(99) < req_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_operation      <= op;
        i_payload_tag    <= tag;
        i_payload_length <= len;
        i_ack_number     <= ack;
        i_ack_good       <= good;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_request(op, tag, len, ack, good);
    endtask

    task automatic send_new(input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len);
        send_request(OP_NEW, tag, len, $urandom, 1'($urandom));
    endtask

    task automatic send_ack(input logic [SEQ_W-1:0] ack, input logic good);
        send_request(OP_ACK, TAG_W'($urandom), LEN_W'($urandom), ack, good);
    endtask

    task automatic send_timeout();
        send_request(OP_TIMEOUT, TAG_W'($urandom), LEN_W'($urandom), $urandom,
                     1'($urandom));
    endtask

    task automatic send_end();
        send_request(OP_END, TAG_W'($urandom), LEN_W'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tx_queue.size() != 0);
    endtask

    task automatic configure_window(input logic [WIN_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        win_cfg = value;
    endtask

    task automatic run_traffic(input int count, input int new_pct);
        logic [SEQ_W-1:0] busy;
        logic [LEN_W-1:0] len;
        int               pick;
        repeat (count) begin
            busy = next_seq - base_seq;
            pick = $urandom_range(99);
            if (pick < new_pct) begin
                case ($urandom_range(9))
                    0: len = '0;
                    1: len = LEN_W'($urandom_range(2047, MAX_LEN + 1));
                    default: len = LEN_W'($urandom_range(MAX_LEN, 1));
                endcase
                send_new(TAG_W'($urandom), len);
            end else if (pick < new_pct + (100 - new_pct) * 2 / 3) begin
                if (busy != 0 && $urandom_range(3) != 0) begin
                    send_ack(base_seq + $urandom_range(busy - 1), 1'b1);
                end else begin
                    case ($urandom_range(3))
                        0: send_ack($urandom, 1'($urandom));
                        1: send_ack(base_seq - 1 - $urandom_range(7), 1'b1);
                        2: send_ack(next_seq + $urandom_range(7), 1'b1);
                        default: send_ack(base_seq + $urandom_range(busy), 1'b0);
                    endcase
                end
            end else begin
                send_timeout();
            end
            if ($urandom_range(24) == 0) drain_results();
        end
    endtask

    task automatic test_send_and_resend();
        send_timeout();
        send_ack(32'd0, 1'b1);
        send_new(16'h0000, 11'd1);
        send_new(16'hFFFF, 11'd1024);
        send_new(16'h1234, 11'd0);
        send_new(16'h8001, 11'd2047);
        send_new(16'h7F00, 11'd1025);
        send_timeout();
        send_ack(32'd1, 1'b0);
        send_ack(32'hFFFF_FFFF, 1'b1);
        send_ack(32'd0, 1'b1);
        send_timeout();
    endtask

    task automatic test_window_shrink();
        configure_window(5'd1);
        send_new(16'h5A5A, 11'd64);
        send_timeout();
        send_ack(next_seq - 1, 1'b1);
        send_new(16'hA5A5, 11'd512);
        send_new(16'h0F0F, 11'd100);
    endtask

    task automatic test_window_zero();
        configure_window(5'd0);
        send_new(16'h3C3C, 11'd7);
        send_ack(next_seq - 1, 1'b1);
        send_new(16'hC3C3, 11'd1000);
    endtask

    task automatic test_random_traffic();
        configure_window(5'd31);
        run_traffic(16, 65);
        configure_window(5'd2);
        run_traffic(15, 45);
        req_gap_pct   = 0;
        rsp_stall_pct = 0;
        configure_window(5'd16);
        run_traffic(20, 55);
        req_gap_pct   = 38;
        rsp_stall_pct = 38;
        configure_window(5'd17);
        run_traffic(16, 60);
        configure_window(5'd1);
        run_traffic(14, 45);
        configure_window(5'd12);
        run_traffic(19, 55);
    endtask

    task automatic test_end_of_stream();
        send_ack(next_seq - 1, 1'b1);
        send_new(16'hBEEF, 11'd300);
        send_end();
        send_new(16'h1111, 11'd20);
        send_timeout();
        send_ack(next_seq - 1, 1'b1);
        send_end();
        send_end();
        send_new(16'h2222, 11'd40);
        send_timeout();
    endtask

    task automatic check_field(input string name, input logic [SEQ_W-1:0] want,
            input logic [SEQ_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_tx want;
        i_ready <= ($urandom_range(99) >= rsp_stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (tx_queue.size() == 0) begin
                $error("unrequested result: kind %0d seq %0h", o_kind, o_seq_number);
                error_count++;
            end else begin
                want = tx_queue.pop_front();
                check_field("kind", SEQ_W'(want.kind), SEQ_W'(o_kind));
                check_field("seq_number", want.seq, o_seq_number);
                check_field("out_tag", SEQ_W'(want.tag), SEQ_W'(o_out_tag));
                check_field("out_length", SEQ_W'(want.len), SEQ_W'(o_out_length));
                check_field("last", SEQ_W'(want.last), SEQ_W'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_send_and_resend();
        test_window_shrink();
        test_window_zero();
        test_random_traffic();
        test_end_of_stream();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
